[hw/rtl/tspsg_pkg.sv]
// ============================================================================
// tspsg_pkg - shared definitions for the transport stream PAT section source
// Constants for the PAT section layout and the CRC-32/MPEG-2 byte update.
// ============================================================================
package tspsg_pkg;

    localparam int unsigned PAYLOAD_BYTES_DEF = 183;

    localparam int unsigned PID_W   = 13;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 32;

    localparam logic [PID_W-1:0]  PID_RESET = 13'd4096;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] STUFF     = 8'hFF;

    // section layout: header + program entry, then CRC, then stuffing
    localparam logic [BYTE_W-1:0] HDR_BYTES = 8'd12;
    localparam logic [BYTE_W-1:0] CRC_END   = 8'd16;

    // section header and program entry byte at position idx (0..11)
    function automatic logic [BYTE_W-1:0] header_byte(
        input logic [3:0]       idx,
        input logic [PID_W-1:0] pid
    );
        logic [BYTE_W-1:0] b;
        unique case (idx)
            4'd0:    b = 8'h00;                      // table id
            4'd1:    b = 8'hB0;                      // syntax, length hi
            4'd2:    b = 8'h0D;                      // section length
            4'd3:    b = 8'h00;                      // ts id hi
            4'd4:    b = 8'h01;                      // ts id lo
            4'd5:    b = 8'hC1;                      // version 0, current
            4'd6:    b = 8'h00;                      // section number
            4'd7:    b = 8'h00;                      // last section number
            4'd8:    b = 8'h00;                      // program number hi
            4'd9:    b = 8'h01;                      // program number lo
            4'd10:   b = {3'b111, pid[PID_W-1:8]};   // reserved, PID hi
            default: b = pid[7:0];                   // PID lo
        endcase
        return b;
    endfunction

    // one byte through the CRC-32/MPEG-2 register, MSB first
    function automatic logic [CRC_W-1:0] crc_byte(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {data, 24'd0};
        for (int b = 0; b < 8; b++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[hw/rtl/ts_pat_section_generator_top.sv]
// ============================================================================
// ts_pat_section_generator_top - MPEG-TS PAT payload byte source
// Emits a fixed-length PAT payload, one byte per request item, with a running
// CRC-32/MPEG-2 over the section bytes and 0xFF stuffing after the CRC.
// ============================================================================
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_restart
//  out     | from block| o_out_valid / i_out_stall | o_data_byte, o_byte_index,
//          |           |                           | o_last_byte
//  cfg     | to block  | i_cfg_we                  | i_cfg_data (PMT PID)
//
//  One request item in, one byte item out, in the cycle after it is taken;
//  one item per cycle unless out stalls; 8-step CRC XOR network into r_crc.
//  Reset (synchronous, active low) clears position to 0, CRC to all ones,
//  the PMT PID to 0x1000, and empties the output register.
//  A request is taken while the output register is empty or being drained,
//  so a stall on the out side stalls the in side in the same cycle.
//
module ts_pat_section_generator_top #(
    parameter int unsigned PAYLOAD_BYTES = tspsg_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_restart,
    // byte channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tspsg_pkg::BYTE_W-1:0]   o_data_byte,
    output logic [tspsg_pkg::BYTE_W-1:0]   o_byte_index,
    output logic                           o_last_byte,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [tspsg_pkg::PID_W-1:0]    i_cfg_data
);

    localparam logic [tspsg_pkg::BYTE_W-1:0] LAST_IDX = 8'(PAYLOAD_BYTES - 1);
    localparam logic [tspsg_pkg::BYTE_W-1:0] PAY_LEN  = 8'(PAYLOAD_BYTES);

    // state
    logic [tspsg_pkg::BYTE_W-1:0] r_pos,   n_pos;
    logic [tspsg_pkg::CRC_W-1:0]  r_crc,   n_crc;
    logic [tspsg_pkg::PID_W-1:0]  r_pid;
    // output register
    logic                         r_out_valid, n_out_valid;
    logic [tspsg_pkg::BYTE_W-1:0] r_data,  n_data;
    logic [tspsg_pkg::BYTE_W-1:0] r_index, n_index;
    logic                         r_last,  n_last;

    logic                         in_acc;
    logic [tspsg_pkg::BYTE_W-1:0] idx;
    logic [tspsg_pkg::CRC_W-1:0]  crc_base;
    logic [tspsg_pkg::BYTE_W-1:0] hdr;
    logic [tspsg_pkg::BYTE_W-1:0] crc_sel;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    // current position: restart or out-of-range both start a fresh payload
    assign idx = (i_restart || (r_pos >= PAY_LEN)) ? '0 : r_pos;

    // CRC reloads on byte 0
    assign crc_base = (idx == '0) ? tspsg_pkg::CRC_INIT : r_crc;
    assign hdr      = tspsg_pkg::header_byte(idx[3:0], r_pid);

    // CRC bytes out MSB first at positions 12..15
    always_comb begin
        unique case (idx[1:0])
            2'd0:    crc_sel = r_crc[31:24];
            2'd1:    crc_sel = r_crc[23:16];
            2'd2:    crc_sel = r_crc[15:8];
            default: crc_sel = r_crc[7:0];
        endcase
    end

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_out_valid = r_out_valid && i_out_stall;
        n_data      = r_data;
        n_index     = r_index;
        n_last      = r_last;
        if (in_acc) begin
            n_out_valid = 1'b1;
            n_index     = idx;
            n_last      = (idx == LAST_IDX);
            n_pos       = (idx == LAST_IDX) ? '0 : idx + 8'd1;
            n_crc       = crc_base;
            priority if (idx < tspsg_pkg::HDR_BYTES) begin
                n_data = hdr;
                n_crc  = tspsg_pkg::crc_byte(crc_base, hdr);
            end else if (idx < tspsg_pkg::CRC_END) begin
                n_data = crc_sel;
            end else begin
                n_data = tspsg_pkg::STUFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= tspsg_pkg::CRC_INIT;
            r_pid       <= tspsg_pkg::PID_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_pid <= i_cfg_data;
            end
        end
    end

    // payload side of the output register, no reset
    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_index <= n_index;
        r_last  <= n_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_byte  = r_data;
    assign o_byte_index = r_index;
    assign o_last_byte  = r_last;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < PAY_LEN)
        else $error("position beyond payload");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_byte |-> o_byte_index == LAST_IDX)
        else $error("last flag on wrong index");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_restart |=> o_out_valid && o_byte_index == '0)
        else $error("restart did not emit byte 0");

    a_crc_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && idx == '0 |=>
            r_crc == tspsg_pkg::crc_byte(tspsg_pkg::CRC_INIT, 8'h00))
        else $error("CRC not reloaded at payload start");
`endif

endmodule
